FILE: sv/pidaw_pkg.sv
package pidaw_pkg;

  // Control tick length in milliseconds
  localparam int INTERVAL_MS = 10;

  // Field widths
  localparam int LEVEL_W     = 15;
  localparam int GAIN_W      = 16;
  localparam int DRIVE_W     = 16;
  localparam int IDX_W       = 4;
  localparam int CFG_W       = 16;
  localparam int IN_TDATA_W  = ((LEVEL_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DRIVE_W + 7) / 8) * 8;

  // Internal widths
  localparam int ERR_W   = LEVEL_W + 2;
  localparam int EMAG_W  = LEVEL_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int DMAG_W  = ERR_W;
  localparam int INTEG_W = 48;
  localparam int ISUM_W  = INTEG_W + 1;
  localparam int SUM_W   = INTEG_W + GAIN_W;
  localparam int FRAC_W  = 16;
  localparam int ITERM_SHIFT = 8;

  // Integral increment and difference quotient scaling
  localparam int MUL_I = 256 * INTERVAL_MS;
  localparam int DEN_I = 1000;
  localparam int MUL_D = 1000;
  localparam int DEN_D = INTERVAL_MS;

  localparam int NUM_I_W = EMAG_W + $clog2(MUL_I + 1);
  localparam int NUM_D_W = DMAG_W + $clog2(MUL_D + 1);
  localparam int NUM_W   = (NUM_I_W > NUM_D_W) ? NUM_I_W : NUM_D_W;
  localparam int DEN_MAX = (DEN_I > DEN_D) ? DEN_I : DEN_D;
  localparam int DEN_W   = $clog2(DEN_MAX + 1);
  localparam int CNT_W   = $clog2(NUM_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_I,
    ST_INTEG,
    ST_DIV_D,
    ST_DERIV,
    ST_MUL,
    ST_ADD,
    ST_CLAMP
  } state_t;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } term_t;

  typedef enum logic [IDX_W-1:0] {
    REG_TARGET_LEVEL = 4'd0,
    REG_PROP_GAIN    = 4'd1,
    REG_INTEG_GAIN   = 4'd2,
    REG_DERIV_GAIN   = 4'd3,
    REG_DRIVE_MIN    = 4'd4,
    REG_DRIVE_MAX    = 4'd5,
    REG_ENTER_BAND   = 4'd6,
    REG_EXIT_BAND    = 4'd7
  } reg_index_t;

endpackage

FILE: sv/pid_antiwindup_hysteresis.sv
// PID light controller with conditional-integration anti-windup and an
// on-target hysteresis flag.
// Input stream (s_axis_*): one filtered light sample per control tick.
// Output stream (m_axis_*): one word per sample, the clamped drive level in
// tdata and the on-target flag in tuser.
// Configuration channel (cfg_*): register index and data, always ready;
// write only while no sample is in work. Unknown indexes are ignored.
// From sample accepted to result valid, the serial divider first works out
// the integral increment and then the difference quotient; the serial
// multiplier then forms each of the three gain terms, each followed by an
// accumulate step. One sample is in work at a time; the next is taken in
// the idle state that follows the registering of the result.
// The result sits in an output register: if the receiver stalls, the next
// sample is still taken and worked on, and only its final step waits for
// the register to empty.
// Reset (rst, synchronous): registers return to their defaults, integral,
// previous error and on-target flag clear, no result is pending.
module pid_antiwindup_hysteresis (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [pidaw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [14:0] light_level
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [pidaw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [15:0] drive_level
  output logic                                 m_axis_tuser,   // [0] on_target
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pidaw_pkg::IDX_W-1:0]          cfg_index,
  input  logic [pidaw_pkg::CFG_W-1:0]          cfg_data
);
  import pidaw_pkg::*;

  // Configuration registers
  logic [LEVEL_W-1:0] target_level;
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  integ_gain;
  logic [GAIN_W-1:0]  deriv_gain;
  logic [DRIVE_W-1:0] drive_min;
  logic [DRIVE_W-1:0] drive_max;
  logic [LEVEL_W-1:0] enter_band;
  logic [LEVEL_W-1:0] exit_band;

  // Controller state
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [ERR_W-1:0]   previous_error;
  logic                      within_set;

  // Sequencer and working registers
  state_t                    state;
  state_t                    state_next;
  term_t                     term;
  logic [CNT_W-1:0]          cnt;
  logic signed [ERR_W-1:0]   err;
  logic                      d_neg;
  logic signed [INTEG_W-1:0] integ_new;
  logic [NUM_W-1:0]          num;
  logic [DEN_W-1:0]          rem;
  logic [INTEG_W-1:0]        mc;
  logic [INTEG_W-1:0]        mp_hi;
  logic [GAIN_W-1:0]         mp_lo;
  logic signed [SUM_W-1:0]   sum;
  logic [DRIVE_W-1:0]        out_drive;
  logic                      out_on;

  // Combinational values
  logic                      accept;
  logic                      out_load;
  logic                      last;
  logic signed [ERR_W-1:0]   err_in;
  logic [EMAG_W-1:0]         err_in_mag;
  logic [EMAG_W-1:0]         err_mag;
  logic signed [DIFF_W-1:0]  diff;
  logic [DMAG_W-1:0]         diff_mag;
  logic [DEN_W:0]            rem_sh;
  logic [DEN_W:0]            den_sel;
  logic [DEN_W:0]            rem_sub;
  logic                      q_bit;
  logic [DEN_W-1:0]          rem_next;
  logic signed [ISUM_W-1:0]  inc;
  logic signed [ISUM_W-1:0]  isum;
  logic signed [INTEG_W-1:0] integ_sat;
  logic [INTEG_W-1:0]        integ_mag;
  logic [INTEG_W:0]          mul_add;
  logic [SUM_W-1:0]          product;
  logic [SUM_W-1:0]          term_mag;
  logic                      term_neg;
  logic signed [SUM_W-1:0]   sum_next;
  logic signed [SUM_W-1:0]   hi_lim;
  logic signed [SUM_W-1:0]   lo_lim;
  logic                      above;
  logic                      below;
  logic [DRIVE_W-1:0]        drive_raw;
  logic [DRIVE_W-1:0]        drive_lo;
  logic [DRIVE_W-1:0]        drive_out;
  logic                      err_pos;
  logic                      undo;
  logic                      on_next;

  assign cfg_ready     = 1'b1;
  assign m_axis_tdata  = OUT_TDATA_W'(out_drive);
  assign m_axis_tuser  = out_on;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign last          = (cnt == '0);

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_axis_tvalid) state_next = ST_DIV_I;
      ST_DIV_I: if (last) state_next = ST_INTEG;
      ST_INTEG: state_next = ST_DIV_D;
      ST_DIV_D: if (last) state_next = ST_DERIV;
      ST_DERIV: state_next = ST_MUL;
      ST_MUL:   if (last) state_next = ST_ADD;
      ST_ADD:   state_next = (term == TERM_D) ? ST_CLAMP : ST_MUL;
      ST_CLAMP: if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    out_load      = (state == ST_CLAMP) && (!m_axis_tvalid || m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Error and difference against the previous error
  assign err_in     = ERR_W'(target_level) - ERR_W'(s_axis_tdata[LEVEL_W-1:0]);
  assign err_in_mag = err_in[ERR_W-1] ? EMAG_W'(-err_in) : EMAG_W'(err_in);
  assign err_mag    = err[ERR_W-1] ? EMAG_W'(-err) : EMAG_W'(err);
  assign diff       = {err[ERR_W-1], err} - {previous_error[ERR_W-1], previous_error};
  assign diff_mag   = diff[DIFF_W-1] ? DMAG_W'(-diff) : DMAG_W'(diff);

  // Restoring divider step, one quotient bit a cycle
  assign rem_sh   = {rem, num[NUM_W-1]};
  assign den_sel  = (state == ST_DIV_I) ? (DEN_W+1)'(DEN_I) : (DEN_W+1)'(DEN_D);
  assign q_bit    = (rem_sh >= den_sel);
  assign rem_sub  = rem_sh - den_sel;
  assign rem_next = q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  // Saturating integral update
  assign inc  = err[ERR_W-1] ? -ISUM_W'(num) : ISUM_W'(num);
  assign isum = {integral_sum[INTEG_W-1], integral_sum} + inc;
  always_comb begin
    if (isum[ISUM_W-1] != isum[ISUM_W-2]) begin
      integ_sat = isum[ISUM_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                 : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_sat = isum[INTEG_W-1:0];
    end
  end
  assign integ_mag = integ_new[INTEG_W-1] ? INTEG_W'(-integ_new) : INTEG_W'(integ_new);

  // Shift-add multiplier step, one gain bit a cycle
  assign mul_add = {1'b0, mp_hi} + (mp_lo[0] ? {1'b0, mc} : '0);
  assign product = {mp_hi, mp_lo};

  // Signed accumulation of the finished term
  always_comb begin
    term_mag = product;
    term_neg = 1'b0;
    case (term)
      TERM_P: term_neg = err[ERR_W-1];
      TERM_I: begin
        term_mag = product >> ITERM_SHIFT;
        term_neg = integ_new[INTEG_W-1];
      end
      TERM_D: term_neg = d_neg;
      default: term_neg = 1'b0;
    endcase
  end
  assign sum_next = term_neg ? (sum - term_mag) : (sum + term_mag);

  // Clamp, anti-windup decision and hysteresis
  assign hi_lim  = {{(SUM_W-DRIVE_W-FRAC_W){1'b0}}, drive_max, {FRAC_W{1'b0}}};
  assign lo_lim  = {{(SUM_W-DRIVE_W-FRAC_W){1'b0}}, drive_min, {FRAC_W{1'b0}}};
  assign above   = (sum > hi_lim);
  assign below   = (sum < lo_lim);
  always_comb begin
    priority if (above) drive_raw = drive_max;
    else if (below)     drive_raw = drive_min;
    else                drive_raw = sum[FRAC_W +: DRIVE_W];
  end
  assign drive_lo  = (drive_raw < drive_min) ? drive_min : drive_raw;
  assign drive_out = (drive_lo > drive_max) ? drive_max : drive_lo;
  assign err_pos   = !err[ERR_W-1] && (err != '0);
  assign undo      = (above && err_pos) || (below && err[ERR_W-1]);
  assign on_next   = within_set ? (err_mag <= EMAG_W'(exit_band))
                                : (err_mag <= EMAG_W'(enter_band));

  // Step counter and term select
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      term <= TERM_P;
    end else begin
      unique case (state)
        ST_IDLE:  if (accept) cnt <= CNT_W'(NUM_W - 1);
        ST_DIV_I, ST_DIV_D, ST_MUL: cnt <= cnt - 1'b1;
        ST_INTEG: cnt <= CNT_W'(NUM_W - 1);
        ST_DERIV: begin
          cnt  <= CNT_W'(GAIN_W - 1);
          term <= TERM_P;
        end
        ST_ADD: begin
          cnt <= CNT_W'(GAIN_W - 1);
          if (term == TERM_P) term <= TERM_I;
          else if (term == TERM_I) term <= TERM_D;
        end
        ST_CLAMP: cnt <= cnt;
      endcase
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          err <= err_in;
          num <= NUM_W'(err_in_mag) * NUM_W'(MUL_I);
          rem <= '0;
        end
      end
      ST_DIV_I, ST_DIV_D: begin
        num <= {num[NUM_W-2:0], q_bit};
        rem <= rem_next;
      end
      ST_INTEG: begin
        integ_new <= integ_sat;
        d_neg     <= diff[DIFF_W-1];
        num       <= NUM_W'(diff_mag) * NUM_W'(MUL_D);
        rem       <= '0;
      end
      ST_DERIV: begin
        mc    <= INTEG_W'(err_mag);
        mp_hi <= '0;
        mp_lo <= prop_gain;
        sum   <= '0;
      end
      ST_MUL: begin
        mp_hi <= mul_add[INTEG_W:1];
        mp_lo <= {mul_add[0], mp_lo[GAIN_W-1:1]};
      end
      ST_ADD: begin
        sum   <= sum_next;
        mp_hi <= '0;
        if (term == TERM_P) begin
          mc    <= integ_mag;
          mp_lo <= integ_gain;
        end else begin
          mc    <= INTEG_W'(num);
          mp_lo <= deriv_gain;
        end
      end
      ST_CLAMP: sum <= sum;
    endcase
  end

  // Commit controller state with the result
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum   <= '0;
      previous_error <= '0;
      within_set     <= 1'b0;
    end else if (out_load) begin
      integral_sum   <= undo ? integral_sum : integ_new;
      previous_error <= err;
      within_set     <= on_next;
    end
  end

  // Output register: hold the word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_drive <= drive_out;
      out_on    <= on_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= 15'd12800;
      prop_gain    <= 16'd256;
      integ_gain   <= 16'd0;
      deriv_gain   <= 16'd0;
      drive_min    <= 16'd0;
      drive_max    <= 16'd8191;
      enter_band   <= 15'd256;
      exit_band    <= 15'd512;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_TARGET_LEVEL: target_level <= cfg_data[LEVEL_W-1:0];
        REG_PROP_GAIN:    prop_gain    <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:   integ_gain   <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:   deriv_gain   <= cfg_data[GAIN_W-1:0];
        REG_DRIVE_MIN:    drive_min    <= cfg_data[DRIVE_W-1:0];
        REG_DRIVE_MAX:    drive_max    <= cfg_data[DRIVE_W-1:0];
        REG_ENTER_BAND:   enter_band   <= cfg_data[LEVEL_W-1:0];
        REG_EXIT_BAND:    exit_band    <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/pidaw_checker.sv
module pidaw_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [pidaw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] drive_level
  input logic                              m_axis_tuser    // [0] on_target
);
  import pidaw_pkg::*;

  // No word is pending after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result pending after reset");

  // A sample in work blocks the input side
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a sample is in work");

  // A new word only appears at the end of a sample's work
  a_word_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared with no sample in work");

  // A stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind pid_antiwindup_hysteresis pidaw_checker u_pidaw_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
